// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helper functions for the integer to ASCII
// converter: digit widths, pipeline structure and character encoding.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int BIN_W         = 32;
   localparam int DIGIT_W       = 4;
   localparam int NUM_DIGITS    = 10;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int DD_STAGES     = 8;
   localparam int STEPS_PER_STG = BIN_W / DD_STAGES;
   localparam int LEN_W         = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] DEC_RADIX  = 8'd10;

   localparam logic MODE_DEC = 1'b0;
   localparam logic MODE_HEX = 1'b1;

   typedef struct packed {
      logic               neg;
      logic               hex;
      logic [BCD_W-1:0]   bcd;
      logic [BIN_W-1:0]   bin;
   } dd_type;

   typedef struct packed {
      logic               neg;
      logic [BCD_W-1:0]   digits;
      logic [LEN_W-1:0]   len;
   } conv_type;

   // one shift-add-3 step; hex mode shifts the raw bits through unchanged
   function automatic dd_type dd_step(input dd_type cur);
      dd_type nxt;
      logic [DIGIT_W-1:0] dig;
      nxt = cur;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dig = cur.bcd[i*DIGIT_W +: DIGIT_W];
         if (!cur.hex && dig >= 4'd5) begin
            nxt.bcd[i*DIGIT_W +: DIGIT_W] = dig + 4'd3;
         end
      end
      {nxt.bcd, nxt.bin} = {nxt.bcd[BCD_W-2:0], nxt.bin, 1'b0};
      return nxt;
   endfunction

   // significant digit count, at least one
   function automatic logic [LEN_W-1:0] digit_len(input logic [BCD_W-1:0] digits);
      logic [LEN_W-1:0] len;
      len = LEN_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digits[i*DIGIT_W +: DIGIT_W] != '0) begin
            len = LEN_W'(i + 1);
         end
      end
      return len;
   endfunction

   function automatic logic [7:0] nib2char(input logic [DIGIT_W-1:0] dig);
      logic [7:0] code;
      if ({4'b0, dig} < DEC_RADIX) begin
         code = CHAR_ZERO + {4'b0, dig};
      end else begin
         code = CHAR_A + {4'b0, dig} - DEC_RADIX;
      end
      return code;
   endfunction

endpackage

// ===== rtl/itoa_conv.sv =====
// ----------------------------------------------------------------------------
// itoa_conv
// Elastic conversion pipeline: sign and magnitude stage, eight binary to BCD
// stages of four steps each, and a digit count stage.
// ----------------------------------------------------------------------------
module itoa_conv (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [31:0]             in_value,
   input  logic                    in_mode,
   output logic                    out_valid,
   input  logic                    out_ready,
   output itoa_pkg::conv_type      out_data
);

   localparam int LAST = itoa_pkg::DD_STAGES;

   itoa_pkg::dd_type   stage_ff [0:LAST];
   itoa_pkg::dd_type   stage_in [0:LAST];
   logic               valid_ff [0:LAST];
   logic               valid_in [0:LAST];
   logic [LAST+1:0]    rdy;
   itoa_pkg::conv_type fin_ff;
   logic               fin_valid_ff;
   logic               entry_neg;

   assign rdy[LAST+1] = !fin_valid_ff || out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = fin_valid_ff;
   assign out_data    = fin_ff;

   assign entry_neg   = (in_mode == itoa_pkg::MODE_DEC) && in_value[31];
   assign valid_in[0] = in_valid;

   always_comb begin
      stage_in[0].neg = entry_neg;
      stage_in[0].hex = in_mode;
      stage_in[0].bcd = '0;
      stage_in[0].bin = entry_neg ? (~in_value + 32'd1) : in_value;
   end

   generate
      for (genvar s = 0; s <= LAST; s++) begin : g_stage
         assign rdy[s] = !valid_ff[s] || rdy[s+1];

         if (s > 0) begin : g_dd
            assign valid_in[s] = valid_ff[s-1];

            always_comb begin
               itoa_pkg::dd_type t;
               t = stage_ff[s-1];
               for (int k = 0; k < itoa_pkg::STEPS_PER_STG; k++) begin
                  t = itoa_pkg::dd_step(t);
               end
               stage_in[s] = t;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (rdy[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[s]) begin
               stage_ff[s] <= stage_in[s];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (rdy[LAST+1]) begin
         fin_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[LAST+1]) begin
         fin_ff.neg    <= stage_ff[LAST].neg;
         fin_ff.digits <= stage_ff[LAST].bcd;
         fin_ff.len    <= itoa_pkg::digit_len(stage_ff[LAST].bcd);
      end
   end

endmodule

// ===== rtl/itoa_ser.sv =====
// ----------------------------------------------------------------------------
// itoa_ser
// Character serializer: emits the optional minus and the significant digits,
// most significant first, one per cycle from a registered output.
// ----------------------------------------------------------------------------
module itoa_ser (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  itoa_pkg::conv_type  in_data,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last
);

   logic [itoa_pkg::BCD_W-1:0] digits_ff, digits_in;
   logic [itoa_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic                       active_ff, active_in;
   logic                       sign_ff, sign_in;
   logic                       strobe_ff, strobe_in;
   logic [7:0]                 char_ff, char_in;
   logic                       last_ff, last_in;
   logic                       final_char;
   logic                       load;

   assign final_char = active_ff && !sign_ff && (idx_ff == '0);
   assign in_ready   = !active_ff || final_char;
   assign load       = in_valid && in_ready;

   always_comb begin
      digits_in = digits_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      sign_in   = sign_ff;
      strobe_in = active_ff;
      char_in   = char_ff;
      last_in   = 1'b0;
      if (active_ff) begin
         if (sign_ff) begin
            char_in = itoa_pkg::CHAR_MINUS;
            sign_in = 1'b0;
         end else begin
            char_in = itoa_pkg::nib2char(digits_ff[idx_ff*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W]);
            last_in = final_char;
            idx_in  = idx_ff - 1'b1;
            if (final_char) begin
               active_in = 1'b0;
            end
         end
      end
      if (load) begin
         digits_in = in_data.digits;
         idx_in    = in_data.len - 1'b1;
         sign_in   = in_data.neg;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         sign_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
         sign_ff   <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = strobe_ff && last_ff;

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_char_out == itoa_pkg::CHAR_MINUS) |-> !rsp_last)
      else $error("minus marked as last character");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a character run");

   a_no_load_mid_run: assert property (@(posedge clock) disable iff (reset)
      (load && active_ff) |-> final_char)
      else $error("new request loaded before run ended");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (!active_ff && !$past(active_ff)) |-> !rsp_strobe)
      else $error("strobe while idle");

endmodule

// ===== rtl/integer_to_ascii_digits_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Converts a 32-bit integer to ASCII characters, signed decimal or unsigned
// lowercase hexadecimal, one character per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_value and req_mode with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   Response channel: one character per cycle on rsp_char_out with
//   rsp_strobe high, most significant first; rsp_last marks the final
//   character. Decimal negatives start with '-'. Zero prints "0".
//   A request passes the sign, binary to BCD and digit count stages and
//   the serializer's state and output registers. Each item has 1 to 11
//   characters, emitted by the single output serializer; the ten-deep
//   conversion pipeline in front of it holds further requests, so
//   consecutive runs follow without gaps while requests keep arriving.
//   busy rises when the pipeline is full behind a running serializer.
//   Reset (synchronous) empties the pipeline and the serializer.
//   The receiver cannot stall: each character is valid for one cycle only.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic               req_mode,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_char_out,
   output logic               rsp_last
);

   logic               conv_ready;
   logic               conv_valid;
   logic               ser_ready;
   itoa_pkg::conv_type conv_data;

   assign busy = !conv_ready;

   itoa_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_ready  (conv_ready),
      .in_value  ($unsigned(req_value)),
      .in_mode   (req_mode),
      .out_valid (conv_valid),
      .out_ready (ser_ready),
      .out_data  (conv_data)
   );

   itoa_ser u_ser (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (conv_valid),
      .in_ready     (ser_ready),
      .in_data      (conv_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule
